// ===== src/bfg_pkg.sv =====
// ----------------------------------------------------------------------------
// bfg_pkg
// Types and constants shared by the two-dimensional stack-machine core.
// ----------------------------------------------------------------------------
package bfg_pkg;

  // Command opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Result status codes
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_INT     = 4'd1;
  localparam logic [3:0] ST_CHAR    = 4'd2;
  localparam logic [3:0] ST_HALT    = 4'd3;
  localparam logic [3:0] ST_UNKNOWN = 4'd4;
  localparam logic [3:0] ST_DIV0    = 4'd5;
  localparam logic [3:0] ST_MOD0    = 4'd6;
  localparam logic [3:0] ST_OVER    = 4'd7;
  localparam logic [3:0] ST_BADPUT  = 4'd8;
  localparam logic [3:0] ST_LOADED  = 4'd9;

  // Headings
  localparam logic [1:0] HD_RIGHT = 2'd0;
  localparam logic [1:0] HD_LEFT  = 2'd1;
  localparam logic [1:0] HD_UP    = 2'd2;
  localparam logic [1:0] HD_DOWN  = 2'd3;

  // Cell characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NOT    = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BRIDGE = 8'h23;
  localparam logic [7:0] CH_POP    = 8'h24;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_INNUM  = 8'h26;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_CHR    = 8'h2C;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_INT    = 8'h2E;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_DUP    = 8'h3A;
  localparam logic [7:0] CH_LEFT   = 8'h3C;
  localparam logic [7:0] CH_RIGHT  = 8'h3E;
  localparam logic [7:0] CH_RAND   = 8'h3F;
  localparam logic [7:0] CH_HALT   = 8'h40;
  localparam logic [7:0] CH_SWAP   = 8'h5C;
  localparam logic [7:0] CH_UP     = 8'h5E;
  localparam logic [7:0] CH_HIF    = 8'h5F;
  localparam logic [7:0] CH_GT     = 8'h60;
  localparam logic [7:0] CH_GET    = 8'h67;
  localparam logic [7:0] CH_PUT    = 8'h70;
  localparam logic [7:0] CH_DOWN   = 8'h76;
  localparam logic [7:0] CH_VIF    = 8'h7C;
  localparam logic [7:0] CH_INCHR  = 8'h7E;

  // Command transaction payload
  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         cell_row;
    logic [6:0]         cell_col;
    logic [7:0]         cell_char;
    logic signed [31:0] user_value;
    logic [1:0]         random_dir;
  } cmd_t;

  // Result transaction payload
  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] out_value;
    logic [4:0]         pc_row_out;
    logic [6:0]         pc_col_out;
  } res_t;

endpackage

// ===== src/befunge_stack_machine_step_top.sv =====
// Load and start go straight to the result; a step reads the cell and the stack and executes,
// then may run a division or, when a put grows the used area, a pass over the enlarged rectangle.
// Throughput: one command transaction at a time; the next is taken while a result waits.
// Grid and stack each sit in one single-port-pair RAM; every step reads the cell and up to
// three stack entries in turn, and division runs one bit a cycle.
// Reset (synchronous): the grid is then cleared to spaces cell by cell, no command accepted until done.
// ----------------------------------------------------------------------------
// befunge_stack_machine_step_top
// Two-dimensional stack-machine core: program grid load, run start and step.
// ----------------------------------------------------------------------------
module befunge_stack_machine_step_top #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 128,
  parameter int STACK_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  bfg_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output bfg_pkg::res_t res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data
);
  import bfg_pkg::*;

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RNW    = $clog2(MAX_ROWS + 1);
  localparam int CNW    = $clog2(MAX_COLS + 1);
  localparam int DW     = (RNW > CNW) ? RNW : CNW;
  localparam int GDEPTH = MAX_ROWS * MAX_COLS;
  localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int SCW    = $clog2(STACK_DEPTH + 1);

  typedef enum logic [13:0] {
    S_CLEAR = 14'h0001,
    S_IDLE  = 14'h0002,
    S_CELL  = 14'h0004,
    S_RD1   = 14'h0008,
    S_RD2   = 14'h0010,
    S_RD3   = 14'h0020,
    S_EXEC  = 14'h0040,
    S_DIV   = 14'h0080,
    S_GET   = 14'h0100,
    S_GROW  = 14'h0200,
    S_PUT   = 14'h0400,
    S_PUSH1 = 14'h0800,
    S_PUSH2 = 14'h1000,
    S_DONE  = 14'h2000
  } state_t;

  function automatic logic [GAW-1:0] gaddr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    gaddr = GAW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  // Clamp a configured dimension into 1..hi
  function automatic logic [DW-1:0] clamp_dim(input logic [7:0] v, input int hi);
    if (v == 8'd0) begin
      clamp_dim = DW'(1);
    end else if (int'(v) > hi) begin
      clamp_dim = DW'(hi);
    end else begin
      clamp_dim = DW'(v);
    end
  endfunction

  // Move a coordinate by steps inside 0..m-1, either direction
  function automatic logic [DW-1:0] wrap_step(input logic [DW-1:0] pos, input logic [DW-1:0] m,
                                              input logic fwd, input logic [1:0] steps);
    logic [DW+1:0] t;
    logic [DW+1:0] mm;
    mm = {2'b00, m};
    t  = fwd ? {2'b00, pos} + {{DW{1'b0}}, steps}
             : {2'b00, pos} + (mm << 1) - {{DW{1'b0}}, steps};
    if (t >= mm) t = t - mm;
    if (t >= mm) t = t - mm;
    wrap_step = t[DW-1:0];
  endfunction

  state_t          state;
  cmd_t            cmd_r;
  logic [5:0]      initial_rows;
  logic [7:0]      initial_cols;
  logic [RNW-1:0]  rows_in_use;
  logic [CNW-1:0]  cols_in_use;
  logic [RW-1:0]   pc_row;
  logic [CW-1:0]   pc_col;
  logic [1:0]      heading;
  logic            string_mode;
  logic            halted;
  logic [SCW-1:0]  stack_count;
  logic [GAW-1:0]  clr_addr;
  logic [7:0]      cell_r;
  logic [31:0]     p0, p1, p2;
  logic [3:0]      status_r;
  logic [31:0]     val_r;
  logic [1:0]      steps_r;
  logic            moves_r;
  logic [1:0]      np_r;
  logic [31:0]     push1, push2;
  logic            mod_r;
  logic [RW-1:0]   put_row;
  logic [CW-1:0]   put_col;
  logic [7:0]      put_val;
  logic [RNW-1:0]  new_rows;
  logic [CNW-1:0]  new_cols;
  logic [RW-1:0]   sr;
  logic [CW-1:0]   sc;

  logic            cmd_acc;
  logic            g_we;
  logic [GAW-1:0]  g_waddr, g_raddr;
  logic [7:0]      g_wdata, g_rdata;
  logic            s_we;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [31:0]     s_wdata, s_rdata;
  logic            div_start, div_done;
  logic [31:0]     div_q, div_r;
  logic            full;
  logic            grow_hit;

  // Execute decode results
  logic [3:0]      x_status;
  logic            x_halt;
  logic [31:0]     x_val;
  logic [SCW-1:0]  x_cnt;
  logic [1:0]      x_np;
  logic [31:0]     x_p1, x_p2;
  logic [1:0]      x_head;
  logic            x_smode;
  logic [1:0]      x_steps;
  logic            x_div, x_get, x_put, x_grow;
  logic [SCW-1:0]  drop1, drop2, drop3;
  state_t          x_next;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;
  assign full      = (stack_count >= SCW'(STACK_DEPTH));
  assign grow_hit  = (RNW'(sr) >= rows_in_use) || (CNW'(sc) >= cols_in_use);

  bfg_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );

  bfg_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  bfg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(p1), .divisor(p0),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  // Grid port steering
  always_comb begin
    g_we    = 1'b0;
    g_waddr = clr_addr;
    g_wdata = CH_SPACE;
    g_raddr = gaddr(pc_row, pc_col);
    case (state)
      S_CLEAR: g_we = 1'b1;
      S_IDLE: begin
        if (cmd_acc && cmd.opcode == OP_LOAD && int'(cmd.cell_row) < MAX_ROWS
            && int'(cmd.cell_col) < MAX_COLS) begin
          g_we    = 1'b1;
          g_waddr = gaddr(RW'(cmd.cell_row), CW'(cmd.cell_col));
          g_wdata = cmd.cell_char;
        end
      end
      S_EXEC: g_raddr = gaddr(RW'(p0), CW'(p1));
      S_GROW: begin
        g_we    = grow_hit;
        g_waddr = gaddr(sr, sc);
      end
      S_PUT: begin
        g_we    = 1'b1;
        g_waddr = gaddr(put_row, put_col);
        g_wdata = put_val;
      end
      default: ;
    endcase
  end

  // Stack port steering
  always_comb begin
    s_raddr = SAW'(stack_count - SCW'(1));
    case (state)
      S_RD1:   s_raddr = SAW'(stack_count - SCW'(2));
      S_RD2:   s_raddr = SAW'(stack_count - SCW'(3));
      default: ;
    endcase
    s_we    = (state == S_PUSH1) || (state == S_PUSH2);
    s_waddr = SAW'(stack_count);
    s_wdata = (state == S_PUSH2) ? push2 : push1;
  end

  // Cell decode and operand work
  always_comb begin
    drop1    = (stack_count > SCW'(0)) ? stack_count - SCW'(1) : '0;
    drop2    = (stack_count > SCW'(1)) ? stack_count - SCW'(2) : '0;
    drop3    = (stack_count > SCW'(2)) ? stack_count - SCW'(3) : '0;
    x_status = ST_OK;
    x_halt   = 1'b0;
    x_val    = '0;
    x_cnt    = stack_count;
    x_np     = 2'd0;
    x_p1     = '0;
    x_p2     = '0;
    x_head   = heading;
    x_smode  = string_mode;
    x_steps  = 2'd1;
    x_div    = 1'b0;
    x_get    = 1'b0;
    x_put    = 1'b0;
    x_grow   = 1'b0;
    if (string_mode) begin
      if (cell_r == CH_QUOTE) begin
        x_smode = 1'b0;
      end else if (full) begin
        x_status = ST_OVER;
        x_halt   = 1'b1;
      end else begin
        x_np = 2'd1;
        x_p1 = sext8(cell_r);
      end
    end else if (cell_r inside {[CH_0:CH_9]}) begin
      if (full) begin
        x_status = ST_OVER;
        x_halt   = 1'b1;
      end else begin
        x_np = 2'd1;
        x_p1 = {24'd0, cell_r - CH_0};
      end
    end else begin
      case (cell_r)
        CH_NUL, CH_SPACE: ;
        CH_RIGHT: x_head = HD_RIGHT;
        CH_LEFT:  x_head = HD_LEFT;
        CH_UP:    x_head = HD_UP;
        CH_DOWN:  x_head = HD_DOWN;
        CH_RAND:  x_head = cmd_r.random_dir;
        CH_ADD: begin
          x_cnt = drop2; x_np = 2'd1; x_p1 = p1 + p0;
        end
        CH_SUB: begin
          x_cnt = drop2; x_np = 2'd1; x_p1 = p1 - p0;
        end
        CH_MUL: begin
          x_cnt = drop2; x_np = 2'd1; x_p1 = p1 * p0;
        end
        CH_DIV, CH_MOD: begin
          if (p0 == 32'd0) begin
            x_status = (cell_r == CH_DIV) ? ST_DIV0 : ST_MOD0;
            x_halt   = 1'b1;
          end else begin
            x_cnt = drop2; x_np = 2'd1; x_div = 1'b1;
          end
        end
        CH_NOT: begin
          x_cnt = drop1; x_np = 2'd1; x_p1 = {31'd0, p0 == 32'd0};
        end
        CH_GT: begin
          x_cnt = drop2; x_np = 2'd1; x_p1 = {31'd0, $signed(p1) > $signed(p0)};
        end
        CH_HIF: begin
          x_cnt = drop1; x_head = (p0 != 32'd0) ? HD_LEFT : HD_RIGHT;
        end
        CH_VIF: begin
          x_cnt = drop1; x_head = (p0 != 32'd0) ? HD_UP : HD_DOWN;
        end
        CH_DUP: begin
          if (full) begin
            x_status = ST_OVER;
            x_halt   = 1'b1;
          end else begin
            x_cnt = drop1; x_np = 2'd2; x_p1 = p0; x_p2 = p0;
          end
        end
        CH_SWAP: begin
          x_cnt = drop2; x_np = 2'd2; x_p1 = p0; x_p2 = p1;
        end
        CH_POP: begin
          x_cnt = drop1;
          x_np  = (stack_count == SCW'(0)) ? 2'd1 : 2'd0;
        end
        CH_INT, CH_CHR: begin
          x_cnt    = drop1;
          x_np     = (stack_count == SCW'(0)) ? 2'd1 : 2'd0;
          x_status = (cell_r == CH_INT) ? ST_INT : ST_CHAR;
          x_val    = (cell_r == CH_INT) ? p0 : {24'd0, p0[7:0]};
        end
        CH_BRIDGE: x_steps = 2'd2;
        CH_GET: begin
          x_cnt = drop2; x_np = 2'd1;
          x_get = (p0 < 32'(rows_in_use)) && (p1 < 32'(cols_in_use));
        end
        CH_PUT: begin
          if (p0 >= 32'(MAX_ROWS) || p1 >= 32'(MAX_COLS)) begin
            x_status = ST_BADPUT;
            x_halt   = 1'b1;
          end else begin
            x_cnt  = drop3;
            x_put  = 1'b1;
            x_grow = (p0 >= 32'(rows_in_use)) || (p1 >= 32'(cols_in_use));
          end
        end
        CH_INNUM: begin
          if (full) begin
            x_status = ST_OVER;
            x_halt   = 1'b1;
          end else begin
            x_np = 2'd1; x_p1 = cmd_r.user_value;
          end
        end
        CH_INCHR: begin
          if (full) begin
            x_status = ST_OVER;
            x_halt   = 1'b1;
          end else begin
            x_np = 2'd1; x_p1 = sext8(cmd_r.user_value[7:0]);
          end
        end
        CH_QUOTE: x_smode = 1'b1;
        CH_HALT: begin
          x_status = ST_HALT;
          x_halt   = 1'b1;
        end
        default: begin
          x_status = ST_UNKNOWN;
          x_halt   = 1'b1;
        end
      endcase
    end
    // Next state after execute
    if (x_halt) begin
      x_next = S_DONE;
    end else if (x_div) begin
      x_next = S_DIV;
    end else if (x_get) begin
      x_next = S_GET;
    end else if (x_put) begin
      x_next = x_grow ? S_GROW : S_PUT;
    end else if (x_np != 2'd0) begin
      x_next = S_PUSH1;
    end else begin
      x_next = S_DONE;
    end
  end

  assign div_start = (state == S_EXEC) && x_div && !x_halt;

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      res_valid    <= 1'b0;
      initial_rows <= 6'd25;
      initial_cols <= 8'd80;
      rows_in_use  <= RNW'(clamp_dim(8'd25, MAX_ROWS));
      cols_in_use  <= CNW'(clamp_dim(8'd80, MAX_COLS));
      pc_row       <= '0;
      pc_col       <= '0;
      heading      <= HD_RIGHT;
      string_mode  <= 1'b0;
      halted       <= 1'b1;
      stack_count  <= '0;
      moves_r      <= 1'b0;
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROWS) begin
          initial_rows <= cfg_data[5:0];
        end else begin
          initial_cols <= cfg_data;
        end
      end

      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + GAW'(1);
          if (clr_addr == GAW'(GDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_acc) begin
            cmd_r    <= cmd;
            val_r    <= '0;
            status_r <= ST_OK;
            moves_r  <= 1'b0;
            state    <= S_DONE;
            case (cmd.opcode)
              OP_LOAD: status_r <= ST_LOADED;
              OP_START: begin
                pc_row      <= '0;
                pc_col      <= '0;
                heading     <= HD_RIGHT;
                stack_count <= '0;
                string_mode <= 1'b0;
                halted      <= 1'b0;
                rows_in_use <= RNW'(clamp_dim({2'b00, initial_rows}, MAX_ROWS));
                cols_in_use <= CNW'(clamp_dim(initial_cols, MAX_COLS));
              end
              OP_STEP: begin
                if (halted) begin
                  status_r <= ST_HALT;
                end else begin
                  state <= S_CELL;
                end
              end
              default: ;
            endcase
          end
        end
        S_CELL: begin
          cell_r <= g_rdata;
          state  <= S_RD1;
        end
        S_RD1: begin
          p0    <= (stack_count > SCW'(0)) ? s_rdata : '0;
          state <= S_RD2;
        end
        S_RD2: begin
          p1    <= (stack_count > SCW'(1)) ? s_rdata : '0;
          state <= S_RD3;
        end
        S_RD3: begin
          p2    <= (stack_count > SCW'(2)) ? s_rdata : '0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          status_r <= x_status;
          val_r    <= x_val;
          state    <= x_next;
          if (x_halt) begin
            halted  <= 1'b1;
            moves_r <= 1'b0;
          end else begin
            moves_r     <= 1'b1;
            stack_count <= x_cnt;
            heading     <= x_head;
            string_mode <= x_smode;
            steps_r     <= x_steps;
            np_r        <= x_np;
            push1       <= x_p1;
            push2       <= x_p2;
            mod_r       <= (cell_r == CH_MOD);
            put_row     <= RW'(p0);
            put_col     <= CW'(p1);
            put_val     <= p2[7:0];
            new_rows    <= (p0 >= 32'(rows_in_use)) ? RNW'(p0 + 32'd1) : rows_in_use;
            new_cols    <= (p1 >= 32'(cols_in_use)) ? CNW'(p1 + 32'd1) : cols_in_use;
            sr          <= '0;
            sc          <= '0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            push1 <= mod_r ? div_r : div_q;
            state <= S_PUSH1;
          end
        end
        S_GET: begin
          push1 <= sext8(g_rdata);
          state <= S_PUSH1;
        end
        // Blank the newly exposed part of the enlarged rectangle
        S_GROW: begin
          if (CNW'(sc) == new_cols - CNW'(1)) begin
            sc <= '0;
            if (RNW'(sr) == new_rows - RNW'(1)) begin
              rows_in_use <= new_rows;
              cols_in_use <= new_cols;
              state       <= S_PUT;
            end else begin
              sr <= sr + RW'(1);
            end
          end else begin
            sc <= sc + CW'(1);
          end
        end
        S_PUT: state <= S_DONE;
        S_PUSH1: begin
          stack_count <= stack_count + SCW'(1);
          state       <= (np_r == 2'd2) ? S_PUSH2 : S_DONE;
        end
        S_PUSH2: begin
          stack_count <= stack_count + SCW'(1);
          state       <= S_DONE;
        end
        // Move the counter, then hand the result to the output register
        S_DONE: begin
          if (moves_r) begin
            moves_r <= 1'b0;
            case (heading)
              HD_RIGHT: pc_col <= CW'(wrap_step(DW'(pc_col), DW'(cols_in_use), 1'b1, steps_r));
              HD_LEFT:  pc_col <= CW'(wrap_step(DW'(pc_col), DW'(cols_in_use), 1'b0, steps_r));
              HD_UP:    pc_row <= RW'(wrap_step(DW'(pc_row), DW'(rows_in_use), 1'b0, steps_r));
              default:  pc_row <= RW'(wrap_step(DW'(pc_row), DW'(rows_in_use), 1'b1, steps_r));
            endcase
          end else if (!res_valid || !res_stall) begin
            res_valid      <= 1'b1;
            res.status     <= status_r;
            res.out_value  <= val_r;
            res.pc_row_out <= 5'(pc_row);
            res.pc_col_out <= 7'(pc_col);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_pc_row: assert property (@(posedge clk) disable iff (rst)
    RNW'(pc_row) < rows_in_use)
    else $error("counter row outside used area");
  a_pc_col: assert property (@(posedge clk) disable iff (rst)
    CNW'(pc_col) < cols_in_use)
    else $error("counter column outside used area");
  a_halt_freeze: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && x_halt) |=> $stable(stack_count) && $stable(pc_row) && $stable(pc_col))
    else $error("faulting step changed machine state");
`endif

endmodule

// ===== src/bfg_ram.sv =====
// ----------------------------------------------------------------------------
// bfg_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bfg_div.sv =====
// ----------------------------------------------------------------------------
// bfg_div
// Iterative signed 32-bit divider, one quotient bit a cycle, truncating.
// ----------------------------------------------------------------------------
module bfg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] acc;
  logic [31:0] q;
  logic [31:0] ub;
  logic        qneg;
  logic        rneg;
  logic [32:0] shifted;
  logic        ge;

  // One restoring step
  assign shifted = {acc[31:0], q[31]};
  assign ge      = shifted >= {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        acc  <= '0;
        q    <= dividend[31] ? -dividend : dividend;
        ub   <= divisor[31] ? -divisor : divisor;
        qneg <= dividend[31] ^ divisor[31];
        rneg <= dividend[31];
      end else if (busy) begin
        acc <= ge ? shifted - {1'b0, ub} : shifted;
        q   <= {q[30:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign fix-up
  assign quot = qneg ? -q : q;
  assign rem  = rneg ? -acc[31:0] : acc[31:0];

endmodule

// ===== bench/befunge_stack_machine_step_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// befunge_stack_machine_step_top_tb
// Self-checking bench for the two-dimensional stack-machine core. Loads
// small programs, starts runs and single-steps them. A behavioural model of
// the grid, stack and counter predicts every result, which is checked field
// by field. It runs directed programs, random programs under random stalls
// on both channels, a receiver hold, overflow, and unstalled random runs.
// ----------------------------------------------------------------------------
module befunge_stack_machine_step_top_tb;
  import bfg_pkg::*;

  localparam int NROWS = 32;
  localparam int NCOLS = 128;
  localparam int DEPTH = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_ROWS;
  logic [7:0] cfg_data = 8'd0;

  befunge_stack_machine_step_top u_top (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model state
  logic [7:0]  grid [0:NROWS*NCOLS-1];
  logic [31:0] stk [0:DEPTH-1];
  int unsigned sp;
  int unsigned pc_r, pc_c;
  logic [1:0]  heading;
  bit          str_mode, halted;
  int unsigned rows_used, cols_used;
  int unsigned cfg_rows = 25, cfg_cols = 80;

  res_t result_q [$];
  int   n_errors = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   tx_pct = 0, rx_pct = 0;
  int   hold_left = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [31:0] peek_at(int unsigned k);
    if (sp > k) return stk[sp-1-k];
    return 32'd0;
  endfunction

  function automatic void drop_n(int unsigned k);
    sp = (sp > k) ? sp - k : 0;
  endfunction

  function automatic void push_v(logic [31:0] v);
    if (sp < DEPTH) begin
      stk[sp] = v;
      sp++;
    end
  endfunction

  function automatic logic [31:0] sx8(logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic void move_pc(int unsigned steps);
    int unsigned r, c;
    r = pc_r % rows_used;
    c = pc_c % cols_used;
    case (heading)
      HD_RIGHT: c = (c + steps) % cols_used;
      HD_LEFT:  c = (c + cols_used - (steps % cols_used)) % cols_used;
      HD_UP:    r = (r + rows_used - (steps % rows_used)) % rows_used;
      default:  r = (r + steps) % rows_used;
    endcase
    pc_r = r;
    pc_c = c;
  endfunction

  function automatic void grow_area(int unsigned need_r, int unsigned need_c);
    int unsigned nr, nc;
    nr = (need_r > rows_used) ? need_r : rows_used;
    nc = (need_c > cols_used) ? need_c : cols_used;
    for (int unsigned r = 0; r < nr; r++)
      for (int unsigned c = 0; c < nc; c++)
        if (r >= rows_used || c >= cols_used) grid[r*NCOLS+c] = CH_SPACE;
    rows_used = nr;
    cols_used = nc;
  endfunction

  // Executes the cell under the counter; returns status, printed value in val
  function automatic logic [3:0] exec_cell(logic [1:0] rdir, logic [31:0] uv,
                                           output logic [31:0] val);
    logic [7:0]  ch;
    logic [31:0] a, b, y, x, v;
    int unsigned steps;
    logic [3:0]  st;
    bit          full;
    ch = grid[pc_r*NCOLS+pc_c];
    steps = 1;
    st = ST_OK;
    val = 32'd0;
    full = (sp >= DEPTH);
    if (str_mode) begin
      if (ch == CH_QUOTE) str_mode = 1'b0;
      else begin
        if (full) begin halted = 1'b1; return ST_OVER; end
        push_v(sx8(ch));
      end
      move_pc(1);
      return ST_OK;
    end
    if (ch >= CH_0 && ch <= CH_9) begin
      if (full) begin halted = 1'b1; return ST_OVER; end
      push_v(32'(ch - CH_0));
      move_pc(1);
      return ST_OK;
    end
    case (ch)
      CH_NUL, CH_SPACE: ;
      CH_RIGHT: heading = HD_RIGHT;
      CH_LEFT:  heading = HD_LEFT;
      CH_UP:    heading = HD_UP;
      CH_DOWN:  heading = HD_DOWN;
      CH_RAND:  heading = rdir;
      CH_ADD: begin b = peek_at(0); a = peek_at(1); drop_n(2); push_v(a + b); end
      CH_SUB: begin b = peek_at(0); a = peek_at(1); drop_n(2); push_v(a - b); end
      CH_MUL: begin b = peek_at(0); a = peek_at(1); drop_n(2); push_v(a * b); end
      CH_DIV, CH_MOD: begin
        b = peek_at(0); a = peek_at(1);
        if (b == 0) begin
          halted = 1'b1;
          return (ch == CH_DIV) ? ST_DIV0 : ST_MOD0;
        end
        drop_n(2);
        // most negative over minus one: quotient is itself, remainder 0
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
          push_v((ch == CH_DIV) ? a : 32'd0);
        else if (ch == CH_DIV)
          push_v($signed(a) / $signed(b));
        else
          push_v($signed(a) % $signed(b));
      end
      CH_NOT: begin a = peek_at(0); drop_n(1); push_v((a == 0) ? 32'd1 : 32'd0); end
      CH_GT: begin
        b = peek_at(0); a = peek_at(1); drop_n(2);
        push_v(($signed(a) > $signed(b)) ? 32'd1 : 32'd0);
      end
      CH_HIF: begin a = peek_at(0); drop_n(1); heading = (a != 0) ? HD_LEFT : HD_RIGHT; end
      CH_VIF: begin a = peek_at(0); drop_n(1); heading = (a != 0) ? HD_UP : HD_DOWN; end
      CH_DUP: begin
        if (full) begin halted = 1'b1; return ST_OVER; end
        a = peek_at(0); drop_n(1); push_v(a); push_v(a);
      end
      CH_SWAP: begin b = peek_at(0); a = peek_at(1); drop_n(2); push_v(b); push_v(a); end
      CH_POP: if (sp == 0) push_v(32'd0); else drop_n(1);
      CH_INT, CH_CHR: begin
        if (sp == 0) begin push_v(32'd0); a = 32'd0; end
        else begin a = peek_at(0); drop_n(1); end
        if (ch == CH_INT) begin val = a; st = ST_INT; end
        else begin val = {24'd0, a[7:0]}; st = ST_CHAR; end
      end
      CH_BRIDGE: steps = 2;
      CH_GET: begin
        y = peek_at(0); x = peek_at(1); drop_n(2);
        v = 32'd0;
        if (y < rows_used && x < cols_used) v = sx8(grid[y*NCOLS+x]);
        push_v(v);
      end
      CH_PUT: begin
        y = peek_at(0); x = peek_at(1); v = peek_at(2);
        if (y >= NROWS || x >= NCOLS) begin halted = 1'b1; return ST_BADPUT; end
        drop_n(3);
        if (y >= rows_used || x >= cols_used) grow_area(y + 1, x + 1);
        grid[y*NCOLS+x] = v[7:0];
      end
      CH_INNUM: begin
        if (full) begin halted = 1'b1; return ST_OVER; end
        push_v(uv);
      end
      CH_INCHR: begin
        if (full) begin halted = 1'b1; return ST_OVER; end
        push_v(sx8(uv[7:0]));
      end
      CH_QUOTE: str_mode = 1'b1;
      CH_HALT: begin halted = 1'b1; return ST_HALT; end
      default: begin halted = 1'b1; return ST_UNKNOWN; end
    endcase
    move_pc(steps);
    return st;
  endfunction

  // Works out the result of one accepted command and queues it
  function automatic void predict_result(cmd_t c);
    res_t r;
    logic [31:0] val;
    r = '0;
    val = 32'd0;
    case (c.opcode)
      OP_LOAD: begin
        grid[c.cell_row*NCOLS+c.cell_col] = c.cell_char;
        r.status = ST_LOADED;
      end
      OP_START: begin
        pc_r = 0; pc_c = 0; heading = HD_RIGHT;
        sp = 0; str_mode = 1'b0; halted = 1'b0;
        rows_used = clamp_dim(cfg_rows, NROWS);
        cols_used = clamp_dim(cfg_cols, NCOLS);
        r.status = ST_OK;
      end
      OP_STEP: r.status = halted ? ST_HALT : exec_cell(c.random_dir, c.user_value, val);
      default: r.status = ST_OK;
    endcase
    r.out_value  = val;
    r.pc_row_out = pc_r[4:0];
    r.pc_col_out = pc_c[6:0];
    result_q.push_back(r);
  endfunction

  // Result monitor and receiver stall generator
  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && !res_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result %h", $time, res);
      end else begin
        e = result_q.pop_front();
        if (res.status !== e.status) begin
          n_errors++;
          $display("%0t: status exp %0d got %0d", $time, e.status, res.status);
        end
        if (res.out_value !== e.out_value) begin
          n_errors++;
          $display("%0t: out_value exp %0d got %0d", $time, e.out_value, res.out_value);
        end
        if (res.pc_row_out !== e.pc_row_out) begin
          n_errors++;
          $display("%0t: pc_row exp %0d got %0d", $time, e.pc_row_out, res.pc_row_out);
        end
        if (res.pc_col_out !== e.pc_col_out) begin
          n_errors++;
          $display("%0t: pc_col exp %0d got %0d", $time, e.pc_col_out, res.pc_col_out);
        end
      end
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // Sends one command transaction, predicting at acceptance
  task automatic send_cmd(cmd_t c);
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_result(c);
    n_items++;
    if ($urandom_range(99) < tx_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic cmd_t rand_cmd(logic [1:0] op);
    cmd_t c;
    c.opcode     = op;
    c.cell_row   = 5'($urandom);
    c.cell_col   = 7'($urandom);
    c.cell_char  = 8'($urandom);
    c.user_value = $urandom;
    c.random_dir = 2'($urandom);
    return c;
  endfunction

  task automatic load_cell(int unsigned r, int unsigned c, logic [7:0] ch);
    cmd_t x;
    x = rand_cmd(OP_LOAD);
    x.cell_row  = r[4:0];
    x.cell_col  = c[6:0];
    x.cell_char = ch;
    send_cmd(x);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ROWS) cfg_rows = data & 8'h3F;
    else cfg_cols = data;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_area(logic [7:0] rows, logic [7:0] cols);
    wait_idle();
    write_cfg(CFG_ROWS, rows);
    write_cfg(CFG_COLS, cols);
  endtask

  // One-row program: load, start, then single-step
  task automatic run_line(string prog, int nsteps, logic [31:0] uv);
    cmd_t c;
    set_area(8'd1, 8'(prog.len()));
    for (int i = 0; i < prog.len(); i++) load_cell(0, i, prog[i]);
    send_cmd(rand_cmd(OP_START));
    for (int i = 0; i < nsteps; i++) begin
      c = rand_cmd(OP_STEP);
      c.user_value = uv;
      c.random_dir = 2'(i);
      send_cmd(c);
    end
  endtask

  task automatic test_directed();
    cmd_t c;
    send_cmd(rand_cmd(OP_STEP));          // step before any start
    c = rand_cmd(2'd3);
    send_cmd(c);                          // unused opcode
    run_line("&~.,", 4, 32'h8000_0080);
    run_line("&~.,", 4, 32'h7FFF_FFFF);
    run_line("98+*.-.", 7, 32'hFFFF_FFFF);
    run_line("&01-/.&01-%.", 12, 32'h8000_0000);
    run_line("70/", 3, 0);
    run_line("70%", 3, 0);
    run_line(":\\$$..,!`_", 14, 0);
    run_line("#@5.@", 4, 0);
    run_line("?", 4, 0);
    run_line("\"A\"..", 5, 0);
    run_line("99g.00g.", 8, 0);
    run_line("765p78g.", 10, 0);
    run_line("001-p", 5, 0);
    run_line("099*9*0p", 8, 0);
    run_line("A", 2, 0);
    run_line("1|", 4, 0);
    // character 0x00 and 0xFF cells, 0xFF pushed in string mode
    set_area(8'd1, 8'd4);
    load_cell(0, 0, CH_QUOTE);
    load_cell(0, 1, 8'hFF);
    load_cell(0, 2, CH_QUOTE);
    load_cell(0, 3, CH_NUL);
    send_cmd(rand_cmd(OP_START));
    repeat (6) send_cmd(rand_cmd(OP_STEP));
  endtask

  // Fills the stack to its depth with a single digit cell, overflows, then steps an oversized area
  task automatic test_overflow();
    set_area(8'd0, 8'd0);
    load_cell(0, 0, CH_9);
    send_cmd(rand_cmd(OP_START));
    repeat (DEPTH + 2) send_cmd(rand_cmd(OP_STEP));
    wait_idle();
    write_cfg(CFG_ROWS, 8'd63);
    write_cfg(CFG_COLS, 8'd255);
    load_cell(0, 0, CH_LEFT);
    send_cmd(rand_cmd(OP_START));
    repeat (3) send_cmd(rand_cmd(OP_STEP));
  endtask

  function automatic logic [7:0] rand_cell_char();
    logic [7:0] ops [26] = '{CH_NOT, CH_QUOTE, CH_BRIDGE, CH_POP, CH_MOD, CH_INNUM,
      CH_MUL, CH_ADD, CH_CHR, CH_SUB, CH_INT, CH_DIV, CH_DUP, CH_LEFT, CH_RIGHT,
      CH_RAND, CH_SWAP, CH_UP, CH_HIF, CH_GT, CH_GET, CH_PUT, CH_DOWN, CH_VIF,
      CH_INCHR, CH_SPACE};
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) return 8'(CH_0 + $urandom_range(9));
    if (p < 94) return ops[$urandom_range(25)];
    if (p < 96) return CH_HALT;
    return 8'($urandom);
  endfunction

  // Random programs in mostly small areas, each stepped a random number of times
  task automatic test_random(int target);
    int unsigned nr, nc, nsteps;
    cmd_t c;
    target += n_items;
    while (n_items < target) begin
      nr = $urandom_range(1, 4);
      nc = $urandom_range(1, 8);
      if ($urandom_range(19) == 0) set_area(8'($urandom_range(0, 63)), 8'($urandom));
      else set_area(8'(nr), 8'(nc));
      for (int unsigned r = 0; r < nr; r++)
        for (int unsigned k = 0; k < nc; k++) load_cell(r, k, rand_cell_char());
      send_cmd(rand_cmd(OP_START));
      nsteps = $urandom_range(15, 45);
      for (int unsigned i = 0; i < nsteps; i++) begin
        if ($urandom_range(19) == 0) c = rand_cmd(2'($urandom));
        else c = rand_cmd(OP_STEP);
        if ($urandom_range(3) == 0)
          c.user_value = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_cmd(c);
        if (halted && $urandom_range(2) == 0) send_cmd(rand_cmd(OP_START));
      end
    end
  endtask

  // Receiver holds off for a long stretch while commands keep coming
  task automatic test_backpressure();
    hold_left = 300;
    run_line("12+.&.", 10, 32'h1234_5678);
  endtask

  initial begin
    for (int i = 0; i < NROWS*NCOLS; i++) grid[i] = CH_SPACE;
    sp = 0; pc_r = 0; pc_c = 0; heading = HD_RIGHT;
    str_mode = 1'b0; halted = 1'b1;
    rows_used = 25; cols_used = 80;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    tx_pct = 37; rx_pct = 77;
    test_random(200);
    tx_pct = 77; rx_pct = 37;
    test_random(200);
    tx_pct = 0; rx_pct = 0;
    test_backpressure();
    test_overflow();
    test_random(200);
    wait_idle();
    repeat (60) @(posedge clk);
    $display("Ran %0d commands with %0d results checked: directed opcodes,", n_items,
             n_results);
    $display("stack overflow, area growth, random programs under stalls.");
    if (n_errors == 0 && result_q.size() == 0)
      $display("befunge_stack_machine_step_top_tb passed");
    else
      $display("befunge_stack_machine_step_top_tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("befunge_stack_machine_step_top_tb failed");
    $finish;
  end

endmodule
